>>> design/bsd_pkg.sv
// Shared types and constants of the bitmap stream pixel decoder.
// No dependencies; the controller, the datapath and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // File header layout, byte offsets from the start of the file.
    localparam int HDR_LEN    = 54;
    localparam int HDR_LAST   = 53;
    localparam int AT_OFFS    = 10;
    localparam int AT_DIB     = 14;
    localparam int AT_WIDTH   = 18;
    localparam int AT_HEIGHT  = 22;
    localparam int AT_BPP     = 28;
    localparam int AT_COMP    = 30;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    localparam int MIN_DIB    = 40;
    localparam int PAL_BASE   = 14;
    localparam int PAL_LEN    = 8;
    localparam int DEPTH_MONO = 1;
    localparam int DEPTH_RGB  = 24;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_GAP,
        PH_PIXELS,
        PH_PENDING,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_HEADER_OK,
        KIND_END
    } kind_t;

    typedef enum logic [3:0] {
        STS_OK,
        STS_SHORT,
        STS_SIGNATURE,
        STS_HEADER,
        STS_COMPRESSED,
        STS_DEPTH,
        STS_WIDTH,
        STS_HEIGHT,
        STS_TRUNCATED,
        STS_PALETTE,
        STS_TOO_LARGE
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_CHK_A,
        CS_CHK_B,
        CS_CHK_C,
        CS_BIT,
        CS_RGB,
        CS_ROW
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic store_hdr;
        logic set_done;
        logic emit_short;
        logic chk_a;
        logic chk_b;
        logic chk_fin;
        logic gap_step;
        logic emit_finish;
        logic bit_step;
        logic rgb_step;
        logic row_step;
    } bsd_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   short_file;
        logic   hdr_pos_ok;
        logic   hdr_last;
        logic   mono;
        logic   bit_last;
        logic   out_free;
    } bsd_stat_t;

endpackage

`default_nettype wire

>>> design/bsd_if.sv
// Handshake channels of the decoder: file words in, result words out, config.
// Depends on nothing; used by the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

interface bsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface bsd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [3:0] status;
    logic [9:0] column;
    logic [9:0] line;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_end;
    modport source (output valid, output item_kind, output status, output column,
                    output line, output red, output green, output blue,
                    output run_end, input ready);
    modport sink (input valid, input item_kind, input status, input column,
                  input line, input red, input green, input blue,
                  input run_end, output ready);
endinterface

interface bsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] file_length;
    modport source (output valid, output file_length, input ready);
    modport sink (input valid, input file_length, output ready);
endinterface

`default_nettype wire

>>> design/bsd_ctrl.sv
// Controller of the decoder: sequences header checks and pixel emission.
// Depends on bsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bsd_pkg::bsd_stat_t stat,
    output bsd_pkg::bsd_cmd_t      cmd
);
    import bsd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = CS_DECODE;
                end
            end
            CS_DECODE:
            begin
                // Every action waits until the output register can take a word.
                if (stat.out_free)
                begin
                    state_next = CS_IDLE;
                    unique case (stat.phase)
                        PH_HEADER:
                        begin
                            if (stat.short_file)
                            begin
                                cmd.emit_short = 1'b1;
                            end
                            else if (stat.hdr_pos_ok)
                            begin
                                cmd.store_hdr = 1'b1;
                                if (stat.hdr_last)
                                begin
                                    state_next = CS_CHK_A;
                                end
                            end
                            else
                            begin
                                cmd.set_done = 1'b1;
                            end
                        end
                        PH_GAP:
                        begin
                            cmd.gap_step = 1'b1;
                        end
                        PH_PIXELS:
                        begin
                            state_next = stat.mono ? CS_BIT : CS_RGB;
                        end
                        PH_PENDING:
                        begin
                            cmd.emit_finish = 1'b1;
                        end
                        default:
                        begin
                            state_next = CS_IDLE;
                        end
                    endcase
                end
            end
            CS_CHK_A:
            begin
                cmd.chk_a  = 1'b1;
                state_next = CS_CHK_B;
            end
            CS_CHK_B:
            begin
                cmd.chk_b  = 1'b1;
                state_next = CS_CHK_C;
            end
            CS_CHK_C:
            begin
                if (stat.out_free)
                begin
                    cmd.chk_fin = 1'b1;
                    state_next  = CS_IDLE;
                end
            end
            CS_BIT:
            begin
                if (stat.out_free)
                begin
                    cmd.bit_step = 1'b1;
                    if (stat.bit_last)
                    begin
                        state_next = CS_ROW;
                    end
                end
            end
            CS_RGB:
            begin
                if (stat.out_free)
                begin
                    cmd.rgb_step = 1'b1;
                    state_next   = CS_ROW;
                end
            end
            CS_ROW:
            begin
                if (stat.out_free)
                begin
                    cmd.row_step = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/bsd_datapath.sv
// Datapath of the decoder: header fields, checks, palette, row walk, output word.
// Depends on bsd_pkg and the channel interfaces in bsd_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module bsd_datapath #(
    parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bsd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         data_byte,
    bsd_cfg_if.sink                 cfg,
    bsd_item_if.source              items,
    input  wire bsd_pkg::bsd_cmd_t  cmd,
    output bsd_pkg::bsd_stat_t      stat
);
    import bsd_pkg::*;

    localparam int STRIDE_MAX = ((MAX_WIDTH * DEPTH_RGB + 31) / 32) * 4;
    localparam int SW = $clog2(STRIDE_MAX + 1);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = SW + 3;
    localparam int PW = SW + RW;
    localparam int BW = CW + 5;

    // Control state.
    logic [31:0] byte_position_reg;
    logic [31:0] file_length_reg;
    phase_t      phase_reg, phase_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] bir_reg, bir_next;
    logic [1:0]  mod3_reg, mod3_next;
    logic [2:0]  k_reg;
    logic        bright_one_reg, bright_one_next;
    logic [23:0] pal_dark_reg, pal_dark_next;
    logic [23:0] pal_bright_reg, pal_bright_next;
    logic        out_valid_reg;

    // Payload.
    logic [31:0] pos_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  sig0_reg, sig1_reg;
    logic [31:0] offs_reg, dib_reg, width_reg, height_reg, comp_reg;
    logic [15:0] bpp_reg;
    status_t     code_reg;
    logic [SW-1:0] stride_reg;
    logic [RW-1:0] hgt_reg;
    logic [CW-1:0] wn_reg;
    logic [SW-1:0] w3_reg;
    logic        top_down_reg;
    logic [PW-1:0] prod_reg;
    logic [32:0] pal_end_reg;
    logic [15:0] partial_reg;
    logic [1:0]  kind_reg;
    logic [3:0]  status_reg;
    logic [9:0]  column_reg, line_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        run_end_reg;

    // Output word being loaded.
    logic        load;
    kind_t       kind_next;
    status_t     status_next;
    logic [9:0]  column_next, line_next;
    logic [7:0]  red_next, green_next, blue_next;
    logic        run_end_next;

    logic [5:0]  pos6;
    logic        mono;
    logic [31:0] hmag;
    logic [CW-1:0] w_n;
    logic [BW-1:0] wbits;
    logic [BW:0] stride_sum;
    status_t     code_a, code_c;
    logic [32:0] end_sum;
    logic [32:0] pal_start, pos_ext, pal_diff;
    logic        in_pal;
    logic [2:0]  pal_off;
    logic [9:0]  lum_dark, lum_bright;
    logic        lum_gt;
    logic [XW-1:0] x_pix, w_x;
    logic        pix_ok, pix_last, bit7_bad;
    logic        row_end, last_row, fin_now;
    logic [RW-1:0] y_n;
    logic        pix_bit, lit;
    logic [23:0] pix_color;
    logic        rgb_emit;
    logic [4:0]  r5, b5;
    logic [5:0]  g6;

    assign cfg.ready = 1'b1;
    assign pos6      = pos_reg[5:0];
    assign mono      = (bpp_reg == 16'(DEPTH_MONO));
    assign hmag      = height_reg[31] ? (32'd0 - height_reg) : height_reg;
    assign w_n       = width_reg[CW-1:0];
    assign wbits     = mono ? BW'(w_n) : ((BW'(w_n) << 4) + (BW'(w_n) << 3));
    assign stride_sum = (BW + 1)'(wbits) + (BW + 1)'(31);

    always_comb
    begin
        priority if (sig0_reg != SIG_B || sig1_reg != SIG_M)
            code_a = STS_SIGNATURE;
        else if (dib_reg < 32'(MIN_DIB) || offs_reg < 32'(HDR_LEN))
            code_a = STS_HEADER;
        else if (comp_reg != 32'd0)
            code_a = STS_COMPRESSED;
        else if (bpp_reg != 16'(DEPTH_MONO) && bpp_reg != 16'(DEPTH_RGB))
            code_a = STS_DEPTH;
        else if (width_reg == 32'd0 || width_reg[31])
            code_a = STS_WIDTH;
        else if (height_reg == 32'd0)
            code_a = STS_HEIGHT;
        else if (width_reg > 32'(MAX_WIDTH) || hmag > 32'(MAX_HEIGHT))
            code_a = STS_TOO_LARGE;
        else
            code_a = STS_OK;
    end

    assign end_sum = {1'b0, offs_reg} + 33'(prod_reg);

    always_comb
    begin
        priority if (code_reg != STS_OK)
            code_c = code_reg;
        else if (end_sum > {1'b0, file_length_reg})
            code_c = STS_TRUNCATED;
        else if (mono && (pal_end_reg > {1'b0, file_length_reg} ||
                          pal_end_reg > {1'b0, offs_reg}))
            code_c = STS_PALETTE;
        else
            code_c = STS_OK;
    end

    // Palette window in the gap between the header and the pixel data.
    assign pal_start  = 33'(PAL_BASE) + {1'b0, dib_reg};
    assign pos_ext    = {1'b0, pos_reg};
    assign pal_diff   = pos_ext - pal_start;
    assign in_pal     = mono && (pos_ext >= pal_start) && (pal_diff < 33'(PAL_LEN));
    assign pal_off    = pal_diff[2:0];
    assign lum_dark   = 10'(pal_dark_reg[23:16]) + 10'(pal_dark_reg[15:8]) +
                        10'(pal_dark_reg[7:0]);
    assign lum_bright = 10'(pal_bright_reg[23:16]) + 10'(pal_bright_reg[15:8]) +
                        10'(pal_bright_reg[7:0]);
    assign lum_gt     = lum_bright > lum_dark;

    // Pixel position within the row and end-of-image detection.
    assign x_pix    = {bir_reg, k_reg};
    assign w_x      = XW'(wn_reg);
    assign pix_ok   = x_pix < w_x;
    assign pix_last = (k_reg == 3'd7) || ((x_pix + XW'(1)) >= w_x);
    assign bit7_bad = {bir_reg, 3'b111} >= w_x;
    assign row_end  = (bir_reg + SW'(1)) >= stride_reg;
    assign last_row = row_end && (((RW + 1)'(row_reg) + (RW + 1)'(1)) >= (RW + 1)'(hgt_reg));
    // A mono byte that fills all eight pixels defers the end word to the next byte.
    assign fin_now  = last_row && (!mono || bit7_bad);
    assign y_n      = top_down_reg ? row_reg : (hgt_reg - RW'(1) - row_reg);
    assign pix_bit  = byte_reg[3'd7 - k_reg];
    assign lit      = bright_one_reg ? pix_bit : ~pix_bit;
    assign pix_color = lit ? pal_bright_reg : pal_dark_reg;
    assign rgb_emit = (bir_reg < w3_reg) && (mod3_reg == 2'd2);
    assign r5       = byte_reg[7:3];
    assign g6       = partial_reg[15:10];
    assign b5       = partial_reg[7:3];

    always_comb
    begin
        stat.phase      = phase_reg;
        stat.short_file = (pos_reg == 32'd0) && (file_length_reg < 32'(HDR_LEN));
        stat.hdr_pos_ok = pos_reg < 32'(HDR_LEN);
        stat.hdr_last   = pos_reg == 32'(HDR_LAST);
        stat.mono       = mono;
        stat.bit_last   = k_reg == 3'd7;
        stat.out_free   = !out_valid_reg || items.ready;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        bir_next        = bir_reg;
        mod3_next       = mod3_reg;
        bright_one_next = bright_one_reg;
        pal_dark_next   = pal_dark_reg;
        pal_bright_next = pal_bright_reg;
        load            = 1'b0;
        kind_next       = KIND_END;
        status_next     = STS_OK;
        column_next     = 10'd0;
        line_next       = 10'd0;
        red_next        = 8'd0;
        green_next      = 8'd0;
        blue_next       = 8'd0;
        run_end_next    = 1'b1;

        if (cmd.emit_short)
        begin
            load        = 1'b1;
            status_next = STS_SHORT;
            phase_next  = PH_DONE;
        end
        if (cmd.set_done)
        begin
            phase_next = PH_DONE;
        end
        if (cmd.chk_fin)
        begin
            load = 1'b1;
            if (code_c != STS_OK)
            begin
                status_next = code_c;
                phase_next  = PH_DONE;
            end
            else
            begin
                kind_next  = KIND_HEADER_OK;
                phase_next = (offs_reg == 32'(HDR_LEN)) ? PH_PIXELS : PH_GAP;
            end
        end
        if (cmd.gap_step)
        begin
            if (in_pal)
            begin
                if (pal_off[1:0] != 2'd3)
                begin
                    if (!pal_off[2])
                        pal_dark_next[8 * pal_off[1:0] +: 8] = byte_reg;
                    else
                        pal_bright_next[8 * pal_off[1:0] +: 8] = byte_reg;
                end
                if (pal_off == 3'd7)
                begin
                    bright_one_next = lum_gt;
                    pal_dark_next   = lum_gt ? pal_dark_reg : pal_bright_reg;
                    pal_bright_next = lum_gt ? pal_bright_reg : pal_dark_reg;
                end
            end
            if (pos_reg + 32'd1 == offs_reg)
            begin
                phase_next = PH_PIXELS;
            end
        end
        if (cmd.emit_finish)
        begin
            load       = 1'b1;
            phase_next = PH_DONE;
        end
        if (cmd.bit_step && pix_ok)
        begin
            load         = 1'b1;
            kind_next    = KIND_PIXEL;
            column_next  = 10'(col_reg);
            line_next    = 10'(y_n);
            red_next     = pix_color[23:16];
            green_next   = pix_color[15:8];
            blue_next    = pix_color[7:0];
            run_end_next = pix_last && !fin_now;
            col_next     = col_reg + CW'(1);
        end
        if (cmd.rgb_step && rgb_emit)
        begin
            load         = 1'b1;
            kind_next    = KIND_PIXEL;
            column_next  = 10'(col_reg);
            line_next    = 10'(y_n);
            red_next     = {r5, r5[4:2]};
            green_next   = {g6, g6[5:4]};
            blue_next    = {b5, b5[4:2]};
            run_end_next = !fin_now;
            col_next     = col_reg + CW'(1);
        end
        if (cmd.row_step)
        begin
            if (row_end)
            begin
                bir_next  = '0;
                col_next  = '0;
                mod3_next = 2'd0;
                row_next  = row_reg + RW'(1);
                if (last_row)
                begin
                    if (fin_now)
                    begin
                        load       = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_PENDING;
                    end
                end
            end
            else
            begin
                bir_next  = bir_reg + SW'(1);
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            file_length_reg   <= '0;
            phase_reg         <= PH_HEADER;
            col_reg           <= '0;
            row_reg           <= '0;
            bir_reg           <= '0;
            mod3_reg          <= '0;
            k_reg             <= '0;
            bright_one_reg    <= 1'b0;
            pal_dark_reg      <= '0;
            pal_bright_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                file_length_reg <= cfg.file_length;
            end
            if (cmd.latch)
            begin
                byte_position_reg <= byte_position_reg + 32'd1;
                k_reg             <= '0;
            end
            else if (cmd.bit_step)
            begin
                k_reg <= k_reg + 3'd1;
            end
            phase_reg      <= phase_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            bir_reg        <= bir_next;
            mod3_reg       <= mod3_next;
            bright_one_reg <= bright_one_next;
            pal_dark_reg   <= pal_dark_next;
            pal_bright_reg <= pal_bright_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (items.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            pos_reg  <= byte_position_reg;
            byte_reg <= data_byte;
        end
        if (cmd.store_hdr)
        begin
            if (pos6 == 6'd0)
                sig0_reg <= byte_reg;
            if (pos6 == 6'd1)
                sig1_reg <= byte_reg;
            if (pos6 >= 6'(AT_OFFS) && pos6 < 6'(AT_OFFS + 4))
                offs_reg[8 * 2'(pos6 - 6'(AT_OFFS)) +: 8] <= byte_reg;
            if (pos6 >= 6'(AT_DIB) && pos6 < 6'(AT_DIB + 4))
                dib_reg[8 * 2'(pos6 - 6'(AT_DIB)) +: 8] <= byte_reg;
            if (pos6 >= 6'(AT_WIDTH) && pos6 < 6'(AT_WIDTH + 4))
                width_reg[8 * 2'(pos6 - 6'(AT_WIDTH)) +: 8] <= byte_reg;
            if (pos6 >= 6'(AT_HEIGHT) && pos6 < 6'(AT_HEIGHT + 4))
                height_reg[8 * 2'(pos6 - 6'(AT_HEIGHT)) +: 8] <= byte_reg;
            if (pos6 >= 6'(AT_BPP) && pos6 < 6'(AT_BPP + 2))
                bpp_reg[8 * 1'(pos6 - 6'(AT_BPP)) +: 8] <= byte_reg;
            if (pos6 >= 6'(AT_COMP) && pos6 < 6'(AT_COMP + 4))
                comp_reg[8 * 2'(pos6 - 6'(AT_COMP)) +: 8] <= byte_reg;
        end
        if (cmd.chk_a)
        begin
            code_reg     <= code_a;
            stride_reg   <= SW'({stride_sum[BW:5], 2'b00});
            hgt_reg      <= hmag[RW-1:0];
            wn_reg       <= w_n;
            w3_reg       <= SW'({w_n, 1'b0}) + SW'(w_n);
            top_down_reg <= height_reg[31];
        end
        if (cmd.chk_b)
        begin
            prod_reg    <= PW'(stride_reg) * PW'(hgt_reg);
            pal_end_reg <= pal_start + 33'(PAL_LEN);
        end
        if (cmd.rgb_step && (bir_reg < w3_reg))
        begin
            if (mod3_reg == 2'd0)
                partial_reg <= {8'd0, byte_reg};
            else if (mod3_reg == 2'd1)
                partial_reg <= {byte_reg, partial_reg[7:0]};
        end
        if (load)
        begin
            kind_reg    <= kind_next;
            status_reg  <= status_next;
            column_reg  <= column_next;
            line_reg    <= line_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            run_end_reg <= run_end_next;
        end
    end

    assign items.valid     = out_valid_reg;
    assign items.item_kind = kind_reg;
    assign items.status    = status_reg;
    assign items.column    = column_reg;
    assign items.line      = line_reg;
    assign items.red       = red_reg;
    assign items.green     = green_reg;
    assign items.blue      = blue_reg;
    assign items.run_end   = run_end_reg;

endmodule

`default_nettype wire

>>> design/bmp_stream_pixel_decoder.sv
// Each file word is latched in the idle state and handled in decode; the last header
// word then passes three check stages, a 24-bit pixel word the RGB and row states, and
// a 1-bit pixel word its eight bits, one pixel per cycle while the output is free.
// Results leave through a registered output word; a stalled output holds the controller.
// Reset clears all control state at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bmp_stream_pixel_decoder #(
    parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bsd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsd_cfg_if.sink    cfg,
    bsd_byte_if.sink   bytes,
    bsd_item_if.source items
);
    import bsd_pkg::*;

    bsd_cmd_t  cmd;
    bsd_stat_t stat;

    bsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_ready (bytes.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (bytes.data_byte),
        .cfg       (cfg),
        .items     (items),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.item_kind == KIND_PIXEL |-> items.status == STS_OK)
        else $error("pixel word carries a nonzero status");

    a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.item_kind != KIND_PIXEL |->
            items.column == 10'd0 && items.line == 10'd0 && items.red == 8'd0 &&
            items.green == 8'd0 && items.blue == 8'd0 && items.run_end)
        else $error("header or end word carries pixel fields");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stat.phase == PH_DONE |=> stat.phase == PH_DONE)
        else $error("decoder left the done phase without reset");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench of bmp_stream_pixel_decoder: builds one bitmap file,
// streams it with random idling, and checks every result word against a predictor.
// Depends on design/bsd_pkg.sv, design/bsd_if.sv and the decoder top level.
`timescale 1ns / 1ps

module tb;
    import bsd_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        kind_t      kind;
        status_t    status;
        logic [9:0] column;
        logic [9:0] line;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_end;
    } result_t;

    typedef struct {
        logic [7:0] value;
        logic       hdr_ok_row;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bsd_cfg_if  cfg();
    bsd_byte_if bytes();
    bsd_item_if items();

    bmp_stream_pixel_decoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .bytes (bytes.sink),
        .items (items.source)
    );

    always #2 clk = ~clk;

    // Predictor state.
    logic [31:0] p_file_length;
    logic [31:0] p_pos;
    logic [7:0]  p_hdr [0:53];
    logic [31:0] p_stride;
    logic [23:0] p_dark;
    logic [23:0] p_bright;
    logic        p_bright_one;
    logic [31:0] p_col;
    logic [31:0] p_row;
    logic [31:0] p_bir;
    logic [15:0] p_partial;
    phase_t      p_phase;

    result_t     pending_results[$];
    int          fails = 0;
    int          taken = 0;
    int          cycles = 0;
    int          rx_max = 17;
    int          tx_max = 17;

    function automatic logic [31:0] hdr32(int at);
        return {p_hdr[at + 3], p_hdr[at + 2], p_hdr[at + 1], p_hdr[at]};
    endfunction

    function automatic logic [31:0] hdr16(int at);
        return {16'd0, p_hdr[at + 1], p_hdr[at]};
    endfunction

    function automatic logic [31:0] height_mag();
        logic [31:0] h;
        h = hdr32(AT_HEIGHT);
        return h[31] ? (32'd0 - h) : h;
    endfunction

    function automatic int brightness(logic [23:0] c);
        return c[23:16] + c[15:8] + c[7:0];
    endfunction

    function automatic void add_result(kind_t k, status_t s, logic [31:0] x, logic [31:0] y,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
        result_t e;
        e.kind = k;
        e.status = s;
        e.column = x[9:0];
        e.line = y[9:0];
        e.red = r;
        e.green = g;
        e.blue = b;
        e.run_end = 1'b0;
        pending_results.insert(pending_results.size(), e);
    endfunction

    function automatic status_t header_verdict();
        logic [31:0] offs, dib, w, h, bpp, comp, hmag;
        longint unsigned last_byte, pal_end;
        offs = hdr32(AT_OFFS);
        dib = hdr32(AT_DIB);
        w = hdr32(AT_WIDTH);
        h = hdr32(AT_HEIGHT);
        bpp = hdr16(AT_BPP);
        comp = hdr32(AT_COMP);
        hmag = height_mag();
        if (p_hdr[0] != SIG_B || p_hdr[1] != SIG_M) return STS_SIGNATURE;
        if (dib < MIN_DIB || offs < HDR_LEN) return STS_HEADER;
        if (comp != 0) return STS_COMPRESSED;
        if (bpp != DEPTH_MONO && bpp != DEPTH_RGB) return STS_DEPTH;
        if (w == 0 || w[31]) return STS_WIDTH;
        if (h == 0) return STS_HEIGHT;
        if (w > DEF_MAX_WIDTH || hmag > DEF_MAX_HEIGHT) return STS_TOO_LARGE;
        p_stride = ((w * bpp + 31) / 32) * 4;
        last_byte = longint'(offs) + longint'(p_stride) * longint'(hmag);
        if (last_byte > p_file_length) return STS_TRUNCATED;
        if (bpp == DEPTH_MONO) begin
            pal_end = PAL_BASE + longint'(dib) + PAL_LEN;
            if (pal_end > p_file_length || pal_end > offs) return STS_PALETTE;
        end
        return STS_OK;
    endfunction

    // Works out the result words caused by one accepted file byte.
    function automatic void decode_byte(logic [7:0] v);
        logic [31:0] pos, w, hgt, y, x, off, c;
        logic [23:0] c0, c1;
        logic [4:0]  r5, b5;
        logic [5:0]  g6;
        longint unsigned p0;
        status_t st;
        int before_n, n;
        logic bit_v, lit;
        before_n = pending_results.size();
        pos = p_pos;
        p_pos = pos + 1;
        case (p_phase)
            PH_HEADER:
            begin
                if (pos == 0 && p_file_length < HDR_LEN) begin
                    add_result(KIND_END, STS_SHORT, 0, 0, 0, 0, 0);
                    p_phase = PH_DONE;
                end else if (pos < HDR_LEN) begin
                    p_hdr[pos] = v;
                    if (pos == HDR_LAST) begin
                        st = header_verdict();
                        if (st != STS_OK) begin
                            add_result(KIND_END, st, 0, 0, 0, 0, 0);
                            p_phase = PH_DONE;
                        end else begin
                            add_result(KIND_HEADER_OK, STS_OK, 0, 0, 0, 0, 0);
                            p_phase = (hdr32(AT_OFFS) == HDR_LEN) ? PH_PIXELS : PH_GAP;
                        end
                    end
                end else begin
                    p_phase = PH_DONE;
                end
            end
            PH_GAP:
            begin
                if (hdr16(AT_BPP) == DEPTH_MONO) begin
                    p0 = PAL_BASE + longint'(hdr32(AT_DIB));
                    if (longint'(pos) >= p0 && longint'(pos) < p0 + PAL_LEN) begin
                        off = 32'(longint'(pos) - p0);
                        if (off[1:0] != 2'd3) begin
                            if (off < 4) p_dark[off[1:0] * 8 +: 8] = v;
                            else p_bright[off[1:0] * 8 +: 8] = v;
                        end
                        if (off == 7) begin
                            c0 = p_dark;
                            c1 = p_bright;
                            p_bright_one = brightness(c1) > brightness(c0);
                            p_dark = p_bright_one ? c0 : c1;
                            p_bright = p_bright_one ? c1 : c0;
                        end
                    end
                end
                if (pos + 1 == hdr32(AT_OFFS)) p_phase = PH_PIXELS;
            end
            PH_PIXELS:
            begin
                w = hdr32(AT_WIDTH);
                hgt = height_mag();
                y = hdr32(AT_HEIGHT) >> 31 ? p_row : (hgt - 1 - p_row);
                if (hdr16(AT_BPP) == DEPTH_MONO) begin
                    for (int k = 0; k < 8; k++) begin
                        x = p_bir * 8 + k;
                        if (x < w) begin
                            bit_v = v[7 - k];
                            lit = p_bright_one ? bit_v : ~bit_v;
                            c = lit ? p_bright : p_dark;
                            add_result(KIND_PIXEL, STS_OK, p_col, y, c[23:16], c[15:8],
                                       c[7:0]);
                            p_col++;
                        end
                    end
                end else if (p_bir < 3 * w) begin
                    case (p_bir % 3)
                        0: p_partial = {8'd0, v};
                        1: p_partial = {v, p_partial[7:0]};
                        default:
                        begin
                            r5 = v[7:3];
                            g6 = p_partial[15:10];
                            b5 = p_partial[7:3];
                            add_result(KIND_PIXEL, STS_OK, p_col, y, {r5, r5[4:2]},
                                       {g6, g6[5:4]}, {b5, b5[4:2]});
                            p_col++;
                        end
                    endcase
                end
                p_bir++;
                if (p_bir >= p_stride) begin
                    p_bir = 0;
                    p_col = 0;
                    p_row++;
                    if (p_row >= hgt) begin
                        if (pending_results.size() - before_n < 8) begin
                            add_result(KIND_END, STS_OK, 0, 0, 0, 0, 0);
                            p_phase = PH_DONE;
                        end else begin
                            p_phase = PH_PENDING;
                        end
                    end
                end
            end
            PH_PENDING:
            begin
                add_result(KIND_END, STS_OK, 0, 0, 0, 0, 0);
                p_phase = PH_DONE;
            end
            default:
            begin
            end
        endcase
        n = pending_results.size();
        if (n > before_n) pending_results[n - 1].run_end = 1'b1;
    endfunction

    task automatic write_length(logic [31:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.file_length <= value;
        do @(posedge clk); while (!cfg.ready);
        p_file_length = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Drives one file word; valid stays high when the next word follows at once.
    task automatic send_byte(logic [7:0] value, logic typed_hdr_ok);
        int gap;
        int last;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            @(negedge clk);
            bytes.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        bytes.valid <= 1'b1;
        bytes.data_byte <= value;
        do @(posedge clk); while (!bytes.ready);
        decode_byte(value);
        if (typed_hdr_ok) begin
            // The header of this file is valid by construction.
            last = pending_results.size() - 1;
            if (last < 0) begin
                $error("item_kind: expected %0d actual none", KIND_HEADER_OK);
                fails++;
            end else begin
                if (pending_results[last].kind != KIND_HEADER_OK) begin
                    $error("item_kind: expected %0d actual %0d", KIND_HEADER_OK,
                           pending_results[last].kind);
                    fails++;
                end
                pending_results[last].kind = KIND_HEADER_OK;
                pending_results[last].status = STS_OK;
                pending_results[last].run_end = 1'b1;
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        bytes.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && items.valid && items.ready) begin
            taken <= taken + 1;
            if (pending_results.size() == 0) begin
                $error("unexpected result word kind %0d status %0d",
                       items.item_kind, items.status);
                fails++;
            end else begin
                e = pending_results.pop_front();
                if (items.item_kind !== e.kind) begin
                    $error("item_kind: expected %0d actual %0d", e.kind, items.item_kind);
                    fails++;
                end
                if (items.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, items.status);
                    fails++;
                end
                if (items.column !== e.column) begin
                    $error("column: expected %0d actual %0d", e.column, items.column);
                    fails++;
                end
                if (items.line !== e.line) begin
                    $error("line: expected %0d actual %0d", e.line, items.line);
                    fails++;
                end
                if (items.red !== e.red) begin
                    $error("red: expected %0d actual %0d", e.red, items.red);
                    fails++;
                end
                if (items.green !== e.green) begin
                    $error("green: expected %0d actual %0d", e.green, items.green);
                    fails++;
                end
                if (items.blue !== e.blue) begin
                    $error("blue: expected %0d actual %0d", e.blue, items.blue);
                    fails++;
                end
                if (items.run_end !== e.run_end) begin
                    $error("run_end: expected %0d actual %0d", e.run_end, items.run_end);
                    fails++;
                end
            end
        end
    end

    // Receiver stalls: a fresh wait is drawn after every accepted word.
    int rx_seen = 0;
    int rx_wait = 0;
    always @(negedge clk)
    begin
        if (taken != rx_seen) begin
            rx_seen <= taken;
            rx_wait = $urandom_range(0, rx_max);
        end
        if (rx_wait > 0) begin
            items.ready <= 1'b0;
            rx_wait--;
        end else begin
            items.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("bmp_stream_pixel_decoder: mismatch");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   header_rows[$];
        stim_row_t   row;
        logic [7:0]  hdr_bytes [0:53];
        logic [31:0] width, height, bpp, offs, stride, total, hmag;
        int          body;
        cfg.valid = 1'b0;
        cfg.file_length = '0;
        bytes.valid = 1'b0;
        bytes.data_byte = '0;
        items.ready = 1'b0;
        p_file_length = 0;
        p_pos = 0;
        p_stride = 0;
        p_dark = 0;
        p_bright = 0;
        p_bright_one = 0;
        p_col = 0;
        p_row = 0;
        p_bir = 0;
        p_partial = 0;
        p_phase = PH_HEADER;
        foreach (p_hdr[i]) p_hdr[i] = 8'd0;

        // One well-formed file; depth, size, orientation and gap are random.
        bpp = $urandom_range(0, 1) ? DEPTH_MONO : DEPTH_RGB;
        width = (bpp == DEPTH_MONO) ? $urandom_range(1, 70) : $urandom_range(1, 20);
        stride = ((width * bpp + 31) / 32) * 4;
        hmag = 200 / stride;
        if (hmag == 0) hmag = 1;
        if (hmag > 60) hmag = 60;
        height = $urandom_range(0, 1) ? (32'd0 - hmag) : hmag;
        offs = HDR_LEN + ((bpp == DEPTH_MONO) ? PAL_LEN : 0) + $urandom_range(0, 6);
        total = offs + stride * hmag + $urandom_range(0, 3);
        foreach (hdr_bytes[i]) hdr_bytes[i] = 8'($urandom);
        hdr_bytes[0] = SIG_B;
        hdr_bytes[1] = SIG_M;
        {hdr_bytes[13], hdr_bytes[12], hdr_bytes[11], hdr_bytes[10]} = offs;
        {hdr_bytes[17], hdr_bytes[16], hdr_bytes[15], hdr_bytes[14]} = MIN_DIB;
        {hdr_bytes[21], hdr_bytes[20], hdr_bytes[19], hdr_bytes[18]} = width;
        {hdr_bytes[25], hdr_bytes[24], hdr_bytes[23], hdr_bytes[22]} = height;
        {hdr_bytes[29], hdr_bytes[28]} = 16'(bpp);
        {hdr_bytes[33], hdr_bytes[32], hdr_bytes[31], hdr_bytes[30]} = 32'd0;
        foreach (hdr_bytes[i])
        begin
            row.value = hdr_bytes[i];
            row.hdr_ok_row = (i == HDR_LAST);
            header_rows.insert(header_rows.size(), row);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Length register extremes first, then the real file length.
        write_length(32'd0);
        write_length(32'hFFFF_FFFF);
        write_length(total);

        foreach (header_rows[i]) send_byte(header_rows[i].value, header_rows[i].hdr_ok_row);

        // Hold the sender until the header word has come out, then rewrite the length.
        drain();
        write_length(total + $urandom_range(0, 255));

        body = total - HDR_LEN;
        for (int i = 0; i < body + 6; i++)
        begin
            if (i % 40 == 0) begin
                tx_max = $urandom_range(0, 3) == 0 ? 0 : 17;
                rx_max = $urandom_range(0, 3) == 0 ? 0 : 17;
            end
            send_byte(8'($urandom), 1'b0);
        end
        drain();

        if (fails == 0)
            $display("bmp_stream_pixel_decoder: match");
        else
            $display("bmp_stream_pixel_decoder: mismatch");
        $finish;
    end

endmodule
